>>> rtl/core/mswd_pkg.sv
// Shared types and constants for the multi-slot watchdog core.
`timescale 1ns / 1ps

package mswd_pkg;

  localparam int DEF_NUM_SLOTS = 16;

  localparam int ACTION_W   = 2;
  localparam int SLOT_ID_W  = 4;
  localparam int INTERVAL_W = 32;

  localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_KICK    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;       // input transfer: latch item, bump tick count on a tick
    logic apply;      // release / kick / refused request
    logic req_step;   // one slot of the free-slot search
    logic tick_step;  // one slot of the expiry scan
    logic out_load;   // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_req_nz;  // item on the input is a request with nonzero interval
    logic in_tick;    // item on the input is a tick
    logic req_done;
    logic tick_done;
  } stat_t;

endpackage

>>> rtl/core/mswd_ctrl.sv
// Sequencing state machine for the multi-slot watchdog core.
`timescale 1ns / 1ps

module mswd_ctrl
  import mswd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_REQ   = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.load       = accept;
    cmd.apply      = (state == S_APPLY);
    cmd.req_step   = (state == S_REQ);
    cmd.tick_step  = (state == S_TICK);
    cmd.out_load   = (state == S_DONE) && out_free;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.in_tick) begin
            state_next = S_TICK;
          end else if (stat.in_req_nz) begin
            state_next = S_REQ;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_APPLY: state_next = S_DONE;
      S_REQ: begin
        if (stat.req_done) state_next = S_DONE;
      end
      S_TICK: begin
        if (stat.tick_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a finished result always lands in the output register on leaving DONE
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("result not delivered from DONE");

  // only one item in flight: no transfer while a result is still being built
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_REQ || state == S_TICK) |-> !cmd.load)
    else $error("input transfer during a scan");

endmodule

>>> rtl/core/mswd_dp.sv
// Slot tables, tick counter, slot scans and result register of the watchdog core.
`timescale 1ns / 1ps

module mswd_dp
  import mswd_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [ACTION_W-1:0]   action,
  input  logic [SLOT_ID_W-1:0]  slot_id,
  input  logic [INTERVAL_W-1:0] interval,
  output logic                  granted,
  output logic [SLOT_ID_W-1:0]  granted_slot,
  output logic                  timeout,
  output logic [SLOT_ID_W-1:0]  timeout_slot
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int WIDE_W = IDX_W + SLOT_ID_W;

  // item
  logic [ACTION_W-1:0]   act_q;
  logic [SLOT_ID_W-1:0]  sid_q;
  logic [INTERVAL_W-1:0] ivl_q;

  logic [INTERVAL_W-1:0] tick_count;
  logic [NUM_SLOTS-1:0]  used;

  logic [INTERVAL_W-1:0] mem_lk  [NUM_SLOTS];
  logic [INTERVAL_W-1:0] mem_ivl [NUM_SLOTS];
  logic [INTERVAL_W-1:0] lk_rd;
  logic [INTERVAL_W-1:0] ivl_rd;

  logic [CNT_W-1:0]      scan_idx;
  logic [IDX_W-1:0]      scan_slot;
  logic                  in_range;
  logic                  free_hit;
  logic                  rd_en;

  logic                  cmp_valid;
  logic                  cmp_used;
  logic [IDX_W-1:0]      cmp_slot;
  logic [INTERVAL_W-1:0] elapsed;
  logic                  hit;

  logic [WIDE_W-1:0]     sid_wide;
  logic [IDX_W-1:0]      sid_idx;
  logic                  sid_ok;
  logic [WIDE_W-1:0]     scan_wide;
  logic [WIDE_W-1:0]     cmp_wide;

  logic                  lk_we;
  logic                  ivl_we;
  logic [IDX_W-1:0]      waddr;
  logic [INTERVAL_W-1:0] lk_wdata;

  logic                  res_granted;
  logic [SLOT_ID_W-1:0]  res_gslot;
  logic                  res_timeout;
  logic [SLOT_ID_W-1:0]  res_tslot;

  assign sid_wide  = {{IDX_W{1'b0}}, sid_q};
  assign sid_idx   = sid_wide[IDX_W-1:0];
  assign sid_ok    = (32'(sid_q) < 32'(NUM_SLOTS));

  assign scan_slot = scan_idx[IDX_W-1:0];
  assign in_range  = (scan_idx < CNT_W'(NUM_SLOTS));
  assign free_hit  = in_range && !used[scan_slot];
  assign rd_en     = cmd.tick_step && in_range;

  // slot numbers go out in the 4-bit field, low bits only
  assign scan_wide = {{SLOT_ID_W{1'b0}}, scan_slot};
  assign cmp_wide  = {{SLOT_ID_W{1'b0}}, cmp_slot};

  // wrap-around elapsed time against the registered table entry
  assign elapsed = tick_count - lk_rd;
  assign hit     = cmp_valid && cmp_used && (elapsed > ivl_rd);

  assign stat.in_req_nz = (action == ACT_REQUEST) && (interval != '0);
  assign stat.in_tick   = (action == ACT_TICK);
  assign stat.req_done  = !in_range || free_hit;
  assign stat.tick_done = hit || (!in_range && !cmp_valid);

  // table write port
  always_comb begin
    lk_we    = 1'b0;
    ivl_we   = 1'b0;
    waddr    = sid_idx;
    lk_wdata = tick_count;
    if (cmd.apply && sid_ok) begin
      if (act_q == ACT_RELEASE) begin
        lk_we    = 1'b1;
        lk_wdata = '0;
      end else if (act_q == ACT_KICK && used[sid_idx]) begin
        lk_we = 1'b1;
      end
    end
    if (cmd.req_step && free_hit) begin
      lk_we  = 1'b1;
      ivl_we = 1'b1;
      waddr  = scan_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) mem_lk[waddr] <= lk_wdata;
    if (ivl_we) mem_ivl[waddr] <= ivl_q;
    if (rd_en) begin
      lk_rd  <= mem_lk[scan_slot];
      ivl_rd <= mem_ivl[scan_slot];
    end
  end

  // a slot is in use exactly when its used bit is set: a grant sets it, a release clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      used       <= '0;
    end else begin
      if (cmd.load && stat.in_tick) tick_count <= tick_count + 32'd1;
      if (cmd.apply && act_q == ACT_RELEASE && sid_ok) used[sid_idx] <= 1'b0;
      if (cmd.req_step && free_hit) used[scan_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q       <= action;
      sid_q       <= slot_id;
      ivl_q       <= interval;
      scan_idx    <= '0;
      cmp_valid   <= 1'b0;
      res_granted <= 1'b0;
      res_gslot   <= '0;
      res_timeout <= 1'b0;
      res_tslot   <= '0;
    end
    if (cmd.req_step) begin
      if (in_range) scan_idx <= scan_idx + CNT_W'(1);
      if (free_hit) begin
        res_granted <= 1'b1;
        res_gslot   <= scan_wide[SLOT_ID_W-1:0];
      end
    end
    if (cmd.tick_step) begin
      if (in_range) scan_idx <= scan_idx + CNT_W'(1);
      cmp_valid <= in_range;
      cmp_used  <= in_range && used[scan_slot];
      cmp_slot  <= scan_slot;
      if (hit) begin
        res_timeout <= 1'b1;
        res_tslot   <= cmp_wide[SLOT_ID_W-1:0];
      end
    end
    if (cmd.out_load) begin
      granted      <= res_granted;
      granted_slot <= res_gslot;
      timeout      <= res_timeout;
      timeout_slot <= res_tslot;
    end
  end

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(res_granted && res_timeout))
    else $error("grant and timeout in one result");

  a_grant_marks_used: assert property (@(posedge clk) disable iff (rst)
    (cmd.req_step && free_hit) |=> (res_granted && used != '0))
    else $error("granted slot not recorded");

  a_tick_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && stat.in_tick) |=> $stable(tick_count))
    else $error("tick count moved without a tick");

endmodule

>>> rtl/core/multi_slot_watchdog_core.sv
// Top level of the multi-slot watchdog core.
`timescale 1ns / 1ps
// Table of NUM_SLOTS watchdog slots with a shared 32-bit tick count.
// Input channel (in_valid / in_stall) carries action, slot_id, interval:
//   request takes the lowest free slot, release frees one, kick re-stamps a
//   slot in use, tick advances the count and reports the lowest expired slot.
// Output channel (out_valid / out_stall) returns one result per item:
//   granted / granted_slot for requests, timeout / timeout_slot for ticks.
// One item is worked on at a time. From input transfer to output valid:
//   release, kick, refused request: through the APPLY and DONE states
//   request: through REQ, scanning past used slots for a free one, then DONE
//   tick: through TICK, a one-slot-per-cycle scan up to the first expired slot
//   through the registered read port of the slot tables, then DONE.
// The next item is taken as soon as the result sits in the output register,
// even while the receiver stalls; a stalled result holds until transferred.
// Reset (rst, synchronous) clears the tick count and frees every slot; no
// clearing pass is needed, slot contents only count for slots in use.

module multi_slot_watchdog_core
  import mswd_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [SLOT_ID_W-1:0]  slot_id,
  input  logic [INTERVAL_W-1:0] interval,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  granted,
  output logic [SLOT_ID_W-1:0]  granted_slot,
  output logic                  timeout,
  output logic [SLOT_ID_W-1:0]  timeout_slot
);

  cmd_t  cmd;
  stat_t stat;

  mswd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mswd_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .slot_id      (slot_id),
    .interval     (interval),
    .granted      (granted),
    .granted_slot (granted_slot),
    .timeout      (timeout),
    .timeout_slot (timeout_slot)
  );

endmodule
